FILE: rtl/cisp_pkg.sv
// cisp_pkg: shared constants, types and codes of the card information tuple parser
// used by every rtl file of the block but cisp_ram; depends on nothing
`timescale 1ns / 1ps

package cisp_pkg;

  // sizing
  localparam int TEXT_CAPACITY = 64;
  localparam int MAX_TUPLES    = 64;
  localparam int SCAN_BYTES    = 6144;
  localparam int STORE_DEPTH   = 64;
  localparam int STORE_AW      = 6;

  localparam logic [12:0] BYTE_SAT  = 13'h1FFF;
  localparam logic [12:0] DEAD_SPAN = 13'd16;

  // tuple codes and characters
  localparam logic [7:0] TPL_NULL   = 8'h00;
  localparam logic [7:0] TPL_END    = 8'hFF;
  localparam logic [7:0] TPL_MANUF  = 8'h20;
  localparam logic [7:0] TPL_VERS   = 8'h15;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_MAKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_CARD  = 1'b1;

  localparam logic [15:0] EXP_MAKER_RST = 16'd50;
  localparam logic [15:0] EXP_CARD_RST  = 16'd1;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LINK,
    PH_BODY
  } walk_phase_e;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_READ,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic step;
    logic rd_en;
    logic emit;
  } cisp_cmd_t;

  typedef struct packed {
    logic fire;
    logic reported;
    logic last_item;
    logic out_free;
  } cisp_status_t;

endpackage

FILE: rtl/cisp_ram.sv
// cisp_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cisp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cisp_ctrl.sv
// cisp_ctrl: controller state machine, scan then report run sequencing
// depends on cisp_pkg
`timescale 1ns / 1ps

module cisp_ctrl
  import cisp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         cmd_i,
  input  cisp_status_t status_i,
  output cisp_cmd_t    cmd_o,
  output logic         in_stall_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SCAN: begin
        if (in_valid_i && cmd_i == CMD_BYTE && !status_i.reported && status_i.fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.last_item ? ST_SCAN : ST_READ;
        end
      end
      default: begin
        state_d = ST_SCAN;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_SCAN: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i == CMD_START) begin
            cmd_o.clear = 1'b1;
          end else if (!status_i.reported) begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cisp_dp.sv
// cisp_dp: datapath, dead check, tuple walk, text store, report and output registers
// depends on cisp_pkg and cisp_ram
`timescale 1ns / 1ps

module cisp_dp
  import cisp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cisp_cmd_t            cmd_i,
  output cisp_status_t         status_o,
  input  logic [7:0]           tuple_byte_i,
  input  logic                 end_of_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 dead_store_o,
  output logic [7:0]           fill_value_o,
  output logic [15:0]          maker_id_o,
  output logic [15:0]          card_id_o,
  output logic                 target_match_o,
  output logic [6:0]           text_length_o,
  output logic [7:0]           text_char_o,
  output logic                 char_valid_o,
  output logic                 last_result_o
);

  // parser state
  logic [7:0]  fill_q, fill_n;
  logic        all_eq_q, all_eq_n;
  logic [12:0] byte_cnt_q, byte_cnt_n;
  logic [6:0]  tpl_cnt_q, tpl_cnt_n;
  walk_phase_e phase_q, phase_n;
  logic [7:0]  code_q, code_n;
  logic [7:0]  link_q, link_n;
  logic [7:0]  pos_q, pos_n;
  logic [15:0] maker_q, maker_n;
  logic [15:0] card_q, card_n;
  logic [6:0]  text_cnt_q, text_cnt_n;
  logic [6:0]  trim_cnt_q, trim_cnt_n;
  logic        done_q, done_n;
  logic        reported_q;

  logic [13:0] nxt;
  logic        fin;
  logic        app;
  logic [7:0]  app_char;
  logic        fire;

  // report summary
  logic        sum_dead_q;
  logic [15:0] sum_maker_q, sum_card_q;
  logic        sum_match_q;
  logic [6:0]  sum_len_q;
  logic [6:0]  item_q;
  logic        last_item;

  logic        dead_n;
  logic [15:0] rep_maker, rep_card;
  logic [6:0]  rep_len;

  logic [15:0] exp_maker_q, exp_card_q;

  logic        out_valid_q;
  logic        out_dead_q, out_match_q, out_cv_q, out_last_q;
  logic [7:0]  out_fill_q, out_char_q;
  logic [15:0] out_maker_q, out_card_q;
  logic [6:0]  out_len_q;

  logic [7:0]  rdata;

  always_comb begin
    fill_n     = fill_q;
    all_eq_n   = all_eq_q;
    tpl_cnt_n  = tpl_cnt_q;
    phase_n    = phase_q;
    code_n     = code_q;
    link_n     = link_q;
    pos_n      = pos_q;
    maker_n    = maker_q;
    card_n     = card_q;
    text_cnt_n = text_cnt_q;
    trim_cnt_n = trim_cnt_q;
    done_n     = done_q;
    fin        = 1'b0;
    app        = 1'b0;
    app_char   = (tuple_byte_i == TPL_NULL) ? CHAR_SPACE : tuple_byte_i;

    if (byte_cnt_q == '0) begin
      fill_n = tuple_byte_i;
    end else if (byte_cnt_q < DEAD_SPAN && tuple_byte_i != fill_q) begin
      all_eq_n = 1'b0;
    end

    nxt = {1'b0, byte_cnt_q} + 14'd1;

    if (!done_q) begin
      case (phase_q)
        PH_CODE: begin
          if (tuple_byte_i == TPL_END) begin
            done_n = 1'b1;
          end else begin
            tpl_cnt_n = tpl_cnt_q + 7'd1;
            if (tuple_byte_i == TPL_NULL) begin
              fin = 1'b1;
            end else begin
              code_n = tuple_byte_i;
              if (tuple_byte_i == TPL_MANUF) begin
                maker_n = '0;
                card_n  = '0;
              end
              phase_n = PH_LINK;
            end
          end
        end
        PH_LINK: begin
          link_n = tuple_byte_i;
          if (tuple_byte_i == TPL_END) begin
            done_n = 1'b1;
          end else if (tuple_byte_i == 8'd0) begin
            fin = 1'b1;
          end else begin
            pos_n   = '0;
            phase_n = PH_BODY;
          end
        end
        PH_BODY: begin
          if (code_q == TPL_MANUF) begin
            case (pos_q)
              8'd0:    maker_n = {maker_q[15:8], tuple_byte_i};
              8'd1:    maker_n = {tuple_byte_i, maker_q[7:0]};
              8'd2:    card_n  = {card_q[15:8], tuple_byte_i};
              8'd3:    card_n  = {tuple_byte_i, card_q[7:0]};
              default: maker_n = maker_q;
            endcase
          end else if (code_q == TPL_VERS && pos_q >= 8'd2) begin
            if (text_cnt_q < 7'(TEXT_CAPACITY)) begin
              app        = 1'b1;
              text_cnt_n = text_cnt_q + 7'd1;
              if (app_char != CHAR_SPACE) begin
                trim_cnt_n = text_cnt_q + 7'd1;
              end
            end
          end
          pos_n = pos_q + 8'd1;
          if (pos_n >= link_q) begin
            fin = 1'b1;
          end
        end
        default: begin
          phase_n = PH_CODE;
        end
      endcase
      if (fin) begin
        phase_n = PH_CODE;
        if (tpl_cnt_n >= 7'(MAX_TUPLES) || nxt >= 14'(SCAN_BYTES)) begin
          done_n = 1'b1;
        end
      end
    end

    byte_cnt_n = (nxt > {1'b0, BYTE_SAT}) ? BYTE_SAT : nxt[12:0];
    fire = end_of_data_i || (byte_cnt_n >= DEAD_SPAN && (done_n || all_eq_n));

    dead_n    = all_eq_n && byte_cnt_n >= DEAD_SPAN;
    rep_maker = dead_n ? 16'd0 : maker_n;
    rep_card  = dead_n ? 16'd0 : card_n;
    rep_len   = dead_n ? 7'd0 : trim_cnt_n;
  end

  assign last_item = (sum_len_q == '0) || (item_q + 7'd1 == sum_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      all_eq_q   <= 1'b1;
      byte_cnt_q <= '0;
      tpl_cnt_q  <= '0;
      phase_q    <= PH_CODE;
      code_q     <= '0;
      link_q     <= '0;
      pos_q      <= '0;
      maker_q    <= '0;
      card_q     <= '0;
      text_cnt_q <= '0;
      trim_cnt_q <= '0;
      done_q     <= 1'b0;
      reported_q <= 1'b0;
    end else if (cmd_i.clear) begin
      fill_q     <= '0;
      all_eq_q   <= 1'b1;
      byte_cnt_q <= '0;
      tpl_cnt_q  <= '0;
      phase_q    <= PH_CODE;
      code_q     <= '0;
      link_q     <= '0;
      pos_q      <= '0;
      maker_q    <= '0;
      card_q     <= '0;
      text_cnt_q <= '0;
      trim_cnt_q <= '0;
      done_q     <= 1'b0;
      reported_q <= 1'b0;
    end else if (cmd_i.step) begin
      fill_q     <= fill_n;
      all_eq_q   <= all_eq_n;
      byte_cnt_q <= byte_cnt_n;
      tpl_cnt_q  <= tpl_cnt_n;
      phase_q    <= phase_n;
      code_q     <= code_n;
      link_q     <= link_n;
      pos_q      <= pos_n;
      maker_q    <= maker_n;
      card_q     <= card_n;
      text_cnt_q <= text_cnt_n;
      trim_cnt_q <= trim_cnt_n;
      done_q     <= done_n;
      reported_q <= fire;
    end
  end

  // summary of the run, taken at the byte that ends the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && fire) begin
      sum_dead_q  <= dead_n;
      sum_maker_q <= rep_maker;
      sum_card_q  <= rep_card;
      sum_len_q   <= rep_len;
      sum_match_q <= dead_n || (rep_maker == exp_maker_q && rep_card == exp_card_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (cmd_i.step && fire) begin
      item_q <= '0;
    end else if (cmd_i.emit) begin
      item_q <= item_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_maker_q <= EXP_MAKER_RST;
      exp_card_q  <= EXP_CARD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXP_MAKER: exp_maker_q <= cfg_data_i;
        CFG_EXP_CARD:  exp_card_q  <= cfg_data_i;
        default:       exp_maker_q <= exp_maker_q;
      endcase
    end
  end

  cisp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.step && app),
    .waddr_i(text_cnt_q[STORE_AW-1:0]),
    .wdata_i(app_char),
    .re_i   (cmd_i.rd_en),
    .raddr_i(item_q[STORE_AW-1:0]),
    .rdata_o(rdata)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_dead_q  <= sum_dead_q;
      out_fill_q  <= fill_q;
      out_maker_q <= sum_maker_q;
      out_card_q  <= sum_card_q;
      out_match_q <= sum_match_q;
      out_len_q   <= sum_len_q;
      out_char_q  <= (sum_len_q == '0) ? 8'd0 : rdata;
      out_cv_q    <= (sum_len_q != '0);
      out_last_q  <= last_item;
    end
  end

  assign status_o.fire      = fire;
  assign status_o.reported  = reported_q;
  assign status_o.last_item = last_item;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign dead_store_o   = out_dead_q;
  assign fill_value_o   = out_fill_q;
  assign maker_id_o     = out_maker_q;
  assign card_id_o      = out_card_q;
  assign target_match_o = out_match_q;
  assign text_length_o  = out_len_q;
  assign text_char_o    = out_char_q;
  assign char_valid_o   = out_cv_q;
  assign last_result_o  = out_last_q;

endmodule

FILE: rtl/card_info_tuple_parser_top.sv
// card_info_tuple_parser_top: top level of the card information tuple parser
// depends on cisp_pkg, cisp_ctrl, cisp_dp and cisp_ram
// Takes one structure byte per cycle while scanning: the dead check and the tuple walk
// both update on every byte taken. When the scan ends, the input is stalled for the
// report run, which gives one word per character of the trimmed version text (one word
// if the text is empty); each word goes through a read of the registered text ram and
// then a load of the output register, which waits while the output is stalled. A start
// command clears the parser; bytes after a finished run are taken and ignored.
`timescale 1ns / 1ps

module card_info_tuple_parser_top
  import cisp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [7:0]           tuple_byte_i,
  input  logic                 end_of_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 dead_store_o,
  output logic [7:0]           fill_value_o,
  output logic [15:0]          maker_id_o,
  output logic [15:0]          card_id_o,
  output logic                 target_match_o,
  output logic [6:0]           text_length_o,
  output logic [7:0]           text_char_o,
  output logic                 char_valid_o,
  output logic                 last_result_o
);

  cisp_cmd_t    cmd;
  cisp_status_t status;

  assign cfg_ready_o = 1'b1;

  cisp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .cmd_i     (cmd_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  cisp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .tuple_byte_i  (tuple_byte_i),
    .end_of_data_i (end_of_data_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .dead_store_o  (dead_store_o),
    .fill_value_o  (fill_value_o),
    .maker_id_o    (maker_id_o),
    .card_id_o     (card_id_o),
    .target_match_o(target_match_o),
    .text_length_o (text_length_o),
    .text_char_o   (text_char_o),
    .char_valid_o  (char_valid_o),
    .last_result_o (last_result_o)
  );

endmodule

FILE: rtl/cisp_checker.sv
// cisp_checker: port level assertions for the card information tuple parser
// depends on cisp_pkg; bound to card_info_tuple_parser_top
`timescale 1ns / 1ps

module cisp_checker
  import cisp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 cmd_i,
  input logic [7:0]           tuple_byte_i,
  input logic                 end_of_data_i,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [15:0]          cfg_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 dead_store_o,
  input logic [7:0]           fill_value_o,
  input logic [15:0]          maker_id_o,
  input logic [15:0]          card_id_o,
  input logic                 target_match_o,
  input logic [6:0]           text_length_o,
  input logic [7:0]           text_char_o,
  input logic                 char_valid_o,
  input logic                 last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(text_char_o) && $stable(last_result_o))
    else $error("output word changed while stalled");

  a_char_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_valid_o == (text_length_o != 7'd0)))
    else $error("char valid disagrees with text length");

  a_dead_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dead_store_o |-> target_match_o && maker_id_o == 16'd0 &&
      card_id_o == 16'd0 && text_length_o == 7'd0 && last_result_o)
    else $error("dead store report is not empty");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> text_length_o <= 7'(TEXT_CAPACITY))
    else $error("text length beyond capacity");

endmodule

bind card_info_tuple_parser_top cisp_checker u_checker (.*);

FILE: verif/card_info_tuple_parser_top_tb.sv
// card_info_tuple_parser_top_tb: self-checking bench for the card information tuple parser
// runs a directed table and then random scans, predicts every report word and checks it
// depends on cisp_pkg and card_info_tuple_parser_top
`timescale 1ns / 1ps

module card_info_tuple_parser_top_tb;
  import cisp_pkg::*;

  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 300;

  typedef struct packed {
    logic        dead;
    logic [7:0]  fill;
    logic [15:0] maker;
    logic [15:0] card;
    logic        match;
    logic [6:0]  len;
    logic [7:0]  chr;
    logic        cv;
    logic        last;
  } report_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       eod;
  } cis_word_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       eod;
    int         reps;
    bit         typed;
    report_t    res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_START;
  logic [7:0]           tuple_byte = 8'h00;
  logic                 eod = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EXP_MAKER;
  logic [15:0]          cfg_data = 16'h0000;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 dead_store;
  logic [7:0]           fill_value;
  logic [15:0]          maker_id;
  logic [15:0]          card_id;
  logic                 target_match;
  logic [6:0]           text_length;
  logic [7:0]           text_char;
  logic                 char_valid;
  logic                 last_result;

  // predicted parser state
  logic [7:0]  cis_fill;
  logic        cis_same;
  logic [12:0] cis_nbytes;
  logic [6:0]  cis_ntuples;
  walk_phase_e cis_phase;
  logic [7:0]  cis_code;
  logic [7:0]  cis_link;
  logic [7:0]  cis_pos;
  logic [15:0] cis_maker;
  logic [15:0] cis_card;
  logic [7:0]  cis_text [STORE_DEPTH];
  logic [6:0]  cis_text_n;
  logic [6:0]  cis_trim_n;
  logic        cis_walk_done;
  logic        cis_reported;
  logic [15:0] want_maker;
  logic [15:0] want_card;

  report_t report_q[$];
  int      n_errors = 0;
  int      cycle_count = 0;
  int      send_idle = 0;
  int      stall_pct = 0;
  bit      hold_armed = 1'b0;
  int      hold_left = 0;

  card_info_tuple_parser_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .tuple_byte_i   (tuple_byte),
    .end_of_data_i  (eod),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dead_store_o   (dead_store),
    .fill_value_o   (fill_value),
    .maker_id_o     (maker_id),
    .card_id_o      (card_id),
    .target_match_o (target_match),
    .text_length_o  (text_length),
    .text_char_o    (text_char),
    .char_valid_o   (char_valid),
    .last_result_o  (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("card_info_tuple_parser_top_tb: done, errors");
      $finish;
    end
  end

  function automatic void clear_scan();
    cis_fill      = 8'h00;
    cis_same      = 1'b1;
    cis_nbytes    = '0;
    cis_ntuples   = '0;
    cis_phase     = PH_CODE;
    cis_code      = 8'h00;
    cis_link      = 8'h00;
    cis_pos       = 8'h00;
    cis_maker     = 16'h0000;
    cis_card      = 16'h0000;
    cis_text_n    = '0;
    cis_trim_n    = '0;
    cis_walk_done = 1'b0;
    cis_reported  = 1'b0;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (c == 8'h00) c = CHAR_SPACE;
    if (cis_text_n < TEXT_CAPACITY) begin
      cis_text[cis_text_n[STORE_AW-1:0]] = c;
      cis_text_n = cis_text_n + 7'd1;
      if (c != CHAR_SPACE) cis_trim_n = cis_text_n;
    end
  endfunction

  function automatic void close_tuple(int next_start);
    cis_phase = PH_CODE;
    if (cis_ntuples >= MAX_TUPLES || next_start >= SCAN_BYTES) cis_walk_done = 1'b1;
  endfunction

  function automatic void walk_chain(logic [7:0] b, int next_start);
    case (cis_phase)
      PH_CODE: begin
        if (b == TPL_END) begin
          cis_walk_done = 1'b1;
          return;
        end
        cis_ntuples = cis_ntuples + 7'd1;
        if (b == TPL_NULL) begin
          close_tuple(next_start);
          return;
        end
        cis_code = b;
        if (b == TPL_MANUF) begin
          cis_maker = 16'h0000;
          cis_card  = 16'h0000;
        end
        cis_phase = PH_LINK;
      end
      PH_LINK: begin
        cis_link = b;
        if (b == TPL_END) begin
          cis_walk_done = 1'b1;
          return;
        end
        if (b == 8'h00) begin
          close_tuple(next_start);
          return;
        end
        cis_pos   = 8'h00;
        cis_phase = PH_BODY;
      end
      default: begin
        if (cis_code == TPL_MANUF) begin
          case (cis_pos)
            8'd0: cis_maker[7:0]  = b;
            8'd1: cis_maker[15:8] = b;
            8'd2: cis_card[7:0]   = b;
            8'd3: cis_card[15:8]  = b;
            default: ;
          endcase
        end else if (cis_code == TPL_VERS && cis_pos >= 8'd2) begin
          add_char(b);
        end
        cis_pos = cis_pos + 8'd1;
        if (cis_pos >= cis_link) close_tuple(next_start);
      end
    endcase
  endfunction

  // returns the number of report words queued for this word
  function automatic int parse_word(cis_word_t w);
    int          idx;
    int          nxt;
    int          len;
    int          n;
    int          k;
    logic        dead;
    logic [15:0] mk;
    logic [15:0] cd;
    report_t     r;
    if (w.cmd == CMD_START) begin
      clear_scan();
      return 0;
    end
    if (cis_reported) return 0;
    idx = cis_nbytes;
    if (idx == 0) cis_fill = w.data;
    else if (idx < DEAD_SPAN && w.data != cis_fill) cis_same = 1'b0;
    nxt = idx + 1;
    if (!cis_walk_done) walk_chain(w.data, nxt);
    cis_nbytes = (nxt > BYTE_SAT) ? BYTE_SAT : nxt[12:0];
    if (!(w.eod || (cis_nbytes >= DEAD_SPAN && (cis_walk_done || cis_same)))) return 0;
    cis_reported = 1'b1;
    dead = cis_same && cis_nbytes >= DEAD_SPAN;
    mk   = dead ? 16'h0000 : cis_maker;
    cd   = dead ? 16'h0000 : cis_card;
    len  = dead ? 0 : cis_trim_n;
    n    = (len == 0) ? 1 : len;
    for (k = 0; k < n; k++) begin
      r.dead  = dead;
      r.fill  = cis_fill;
      r.maker = mk;
      r.card  = cd;
      r.match = dead || (mk == want_maker && cd == want_card);
      r.len   = len[6:0];
      r.chr   = (len == 0) ? 8'h00 : cis_text[k];
      r.cv    = (len != 0);
      r.last  = (k == n - 1);
      report_q.push_back(r);
    end
    return n;
  endfunction

  function automatic cis_word_t mk_word(logic c, logic [7:0] b, logic e);
    cis_word_t w;
    w.cmd  = c;
    w.data = b;
    w.eod  = e;
    return w;
  endfunction

  function automatic report_t empty_run(logic dead, logic [7:0] fill, logic [15:0] maker,
                                        logic [15:0] card, logic match);
    report_t r;
    r.dead  = dead;
    r.fill  = fill;
    r.maker = maker;
    r.card  = card;
    r.match = match;
    r.len   = '0;
    r.chr   = 8'h00;
    r.cv    = 1'b0;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic c, logic [7:0] b, logic e, int reps, bit typed,
                                      report_t res);
    dir_row_t row;
    row.cmd   = c;
    row.data  = b;
    row.eod   = e;
    row.reps  = reps;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : receiver
    report_t want;
    if (out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("report word with no expectation waiting");
        n_errors++;
      end else begin
        want = report_q.pop_front();
        check_field("dead_store", want.dead, dead_store);
        check_field("fill_value", want.fill, fill_value);
        check_field("maker_id", want.maker, maker_id);
        check_field("card_id", want.card, card_id);
        check_field("target_match", want.match, target_match);
        check_field("text_length", want.len, text_length);
        check_field("text_char", want.chr, text_char);
        check_field("char_valid", want.cv, char_valid);
        check_field("last_result", want.last, last_result);
      end
    end
    if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input cis_word_t w, output int made);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= w.cmd;
    tuple_byte <= w.data;
    eod        <= w.eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    made = parse_word(w);
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_targets(logic [15:0] maker, logic [15:0] card);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_EXP_MAKER;
    cfg_data  <= maker;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    want_maker = maker;
    cfg_index <= CFG_EXP_CARD;
    cfg_data  <= card;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    want_card = card;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_scan(output int sent);
    cis_word_t   words[$];
    cis_word_t   w;
    int          kind;
    int          ntup;
    int          r;
    int          link;
    int          nb;
    int          pos;
    int          made;
    logic [7:0]  code;
    logic [7:0]  fill;
    logic [7:0]  ch;
    logic [31:0] ids;
    sent = 0;
    kind = $urandom_range(99);
    if ($urandom_range(9) != 0) words.push_back(mk_word(CMD_START, 8'h00, 1'b0));
    if (kind < 70) begin
      ntup = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(6, 1);
      repeat (ntup) begin
        r = $urandom_range(99);
        // long chains are mostly null tuples so the tuple limit can be reached
        if (ntup > 20 && r < 85) r = 0;
        if (r < 15) begin
          words.push_back(mk_word(CMD_BYTE, TPL_NULL, 1'b0));
        end else begin
          if (r < 45) begin
            code = TPL_MANUF;
            link = ($urandom_range(3) == 0) ? $urandom_range(8, 0) : 4;
          end else if (r < 80) begin
            code = TPL_VERS;
            link = ($urandom_range(7) == 0) ? $urandom_range(90, 60) : $urandom_range(20, 0);
          end else begin
            code = 8'($urandom_range(254, 1));
            link = $urandom_range(10, 0);
          end
          ids = $urandom_range(1) ? {want_card, want_maker} : $urandom();
          words.push_back(mk_word(CMD_BYTE, code, 1'b0));
          words.push_back(mk_word(CMD_BYTE, link[7:0], 1'b0));
          for (pos = 0; pos < link; pos++) begin
            r = $urandom_range(9);
            if (code == TPL_MANUF && pos < 4) ch = ids[8*pos +: 8];
            else if (code == TPL_VERS && pos >= 2 && r < 2) ch = 8'h00;
            else if (code == TPL_VERS && pos >= 2 && r < 4) ch = CHAR_SPACE;
            else ch = 8'($urandom_range(255));
            words.push_back(mk_word(CMD_BYTE, ch, 1'b0));
          end
        end
      end
      r = $urandom_range(9);
      if (r < 4) begin
        words.push_back(mk_word(CMD_BYTE, TPL_END, 1'b0));
      end else if (r < 6) begin
        words.push_back(mk_word(CMD_BYTE, 8'($urandom_range(254, 1)), 1'b0));
        words.push_back(mk_word(CMD_BYTE, TPL_END, 1'b0));
      end else if (r < 8) begin
        w = words.pop_back();
        w.eod = 1'b1;
        words.push_back(w);
      end
      nb = $urandom_range(20, 17);
      while (words.size() < nb) words.push_back(mk_word(CMD_BYTE, 8'($urandom()), 1'b0));
    end else if (kind < 85) begin
      fill = 8'($urandom());
      nb   = $urandom_range(18, 16);
      pos  = ($urandom_range(2) == 0) ? $urandom_range(15, 1) : -1;
      for (r = 0; r < nb; r++) words.push_back(mk_word(CMD_BYTE, (r == pos) ? ~fill : fill, 1'b0));
    end else begin
      nb = $urandom_range(30, 1);
      repeat (nb) begin
        words.push_back(mk_word(($urandom_range(19) == 0) ? CMD_START : CMD_BYTE,
                                8'($urandom()), $urandom_range(9) == 0));
      end
    end
    if ($urandom_range(2) == 0) begin
      w = words.pop_back();
      w.eod = 1'b1;
      words.push_back(w);
    end
    while (words.size() != 0) begin
      w = words.pop_front();
      if (w.cmd == CMD_BYTE) sent++;
      send_word(w, made);
    end
  endtask

  initial begin : stimulus
    dir_row_t rows[$];
    report_t  no_run;
    report_t  dropped;
    int       made;
    int       sent;
    int       total;
    int       ph;
    bit       pressed;
    no_run  = '0;
    pressed = 1'b0;
    clear_scan();
    want_maker = EXP_MAKER_RST;
    want_card  = EXP_CARD_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_targets(EXP_MAKER_RST, EXP_CARD_RST);

    // short structure, then a byte after the run that must be ignored
    rows.push_back(mk_row(CMD_START, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_NULL, 1'b1, 1, 1'b1,
                          empty_run(1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0)));
    rows.push_back(mk_row(CMD_BYTE, 8'h55, 1'b0, 1, 1'b0, no_run));
    // manufacturer tuple naming the wanted card
    rows.push_back(mk_row(CMD_START, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_MANUF, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h04, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, EXP_MAKER_RST[7:0], 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, EXP_MAKER_RST[15:8], 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, EXP_CARD_RST[7:0], 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, EXP_CARD_RST[15:8], 1'b1, 1, 1'b1,
                          empty_run(1'b0, TPL_MANUF, EXP_MAKER_RST, EXP_CARD_RST, 1'b1)));
    // version text with a zero inside
    rows.push_back(mk_row(CMD_START, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_VERS, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h05, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h04, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h01, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h41, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, 8'h42, 1'b1, 1, 1'b0, no_run));
    // end link right after a manufacturer code
    rows.push_back(mk_row(CMD_START, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_MANUF, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_END, 1'b1, 1, 1'b1,
                          empty_run(1'b0, TPL_MANUF, 16'h0000, 16'h0000, 1'b0)));
    // stuck store, all ones
    rows.push_back(mk_row(CMD_START, 8'h00, 1'b0, 1, 1'b0, no_run));
    rows.push_back(mk_row(CMD_BYTE, TPL_END, 1'b0, 16, 1'b1,
                          empty_run(1'b1, TPL_END, 16'h0000, 16'h0000, 1'b1)));

    foreach (rows[i]) begin
      repeat (rows[i].reps) begin
        send_word(mk_word(rows[i].cmd, rows[i].data, rows[i].eod), made);
        if (rows[i].typed && made > 0) begin
          repeat (made) dropped = report_q.pop_back();
          report_q.push_back(rows[i].res);
        end
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      drain(8);
      case (ph)
        0: begin
          send_idle = 0;
          stall_pct = 0;
          set_targets(16'h0000, 16'h0000);
        end
        1: begin
          send_idle = 71;
          stall_pct = 0;
          set_targets(16'hFFFF, 16'hFFFF);
        end
        2: begin
          send_idle = 0;
          stall_pct = 71;
          set_targets(16'($urandom()), 16'($urandom()));
        end
        default: begin
          send_idle = 38;
          stall_pct = 38;
          set_targets(16'($urandom()), 16'($urandom()));
        end
      endcase
      total = 0;
      while (total < 60) begin
        random_scan(sent);
        total += sent;
        // long hold-off on the result side while bytes keep coming
        if (ph == 0 && total >= 30 && !pressed) begin
          hold_armed = 1'b1;
          pressed    = 1'b1;
        end
      end
    end

    drain(20);
    if (n_errors == 0) begin
      $display("card_info_tuple_parser_top_tb: done, clean");
    end else begin
      $display("card_info_tuple_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule
